// ===== hw/rtl/hic_pkg.sv =====
// Shared types, constants and parity helpers for the Hamming (7,4) interleave codec.
// No dependencies; every other file of the codec imports this package.
package hic_pkg;

  localparam int NIBBLES   = 16;
  localparam int CODE_BITS = 7;
  localparam int DATA_BITS = 4;
  localparam int LOW_W     = 64;
  localparam int HIGH_W    = 48;
  localparam int BLOCK_W   = LOW_W + HIGH_W;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } hic_mode_t;

  typedef logic [CODE_BITS-1:0] hic_word_t;
  typedef hic_word_t [NIBBLES-1:0] hic_lanes_t;

  // Beat control that travels alongside the lane results into the merge stage.
  typedef struct packed {
    logic      valid;
    hic_mode_t mode;
  } hic_ctl_t;

  // Check bits {p6, p5, p4} of a data nibble.
  function automatic logic [2:0] hic_parity(input logic [DATA_BITS-1:0] d);
    logic [2:0] p;
    p[0] = d[0] ^ d[2] ^ d[3];
    p[1] = d[0] ^ d[1] ^ d[3];
    p[2] = d[0] ^ d[1] ^ d[2];
    return p;
  endfunction

endpackage

// ===== hw/rtl/hic_lane.sv =====
// One codec lane: encodes a nibble into a 7-bit code or corrects one 7-bit code.
// Depends on hic_pkg.
module hic_lane (
  input  hic_pkg::hic_mode_t mode,
  input  hic_pkg::hic_word_t word_in,
  output hic_pkg::hic_word_t word_out
);
  import hic_pkg::*;

  logic [DATA_BITS-1:0] data;
  logic [2:0]           syndrome;
  logic [DATA_BITS-1:0] fixed;

  assign data     = word_in[DATA_BITS-1:0];
  assign syndrome = word_in[CODE_BITS-1:DATA_BITS] ^ hic_parity(data);

  // A syndrome that names a data bit flips it; a lone check-bit error leaves data alone.
  always_comb begin
    fixed = data;
    case (syndrome)
      3'd7:    fixed = data ^ 4'b0001;
      3'd6:    fixed = data ^ 4'b0010;
      3'd5:    fixed = data ^ 4'b0100;
      3'd3:    fixed = data ^ 4'b1000;
      default: fixed = data;
    endcase
  end

  assign word_out = (mode == MODE_ENCODE) ? {hic_parity(data), data}
                                          : {3'b000, fixed};

endmodule

// ===== hw/rtl/hic_merge.sv =====
// Merge stage: packs the sixteen lane results into one block and holds it in the
// output register until the downstream side takes it. Depends on hic_pkg.
module hic_merge (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hic_pkg::hic_ctl_t             ctl,
  input  hic_pkg::hic_lanes_t           lanes,
  output logic                          load_ok,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hic_pkg::BLOCK_W-1:0]   out_block
);
  import hic_pkg::*;

  logic               valid_r, valid_nxt;
  logic [BLOCK_W-1:0] block_r, block_nxt;
  logic               load;

  assign load_ok = !valid_r || out_ready;
  assign load    = ctl.valid && load_ok;

  // Encode: code bit j of nibble k lands at bit 16*j + k of the coded block.
  // Decode: corrected nibble k lands at bits 4*k+3:4*k, upper bytes are zero.
  always_comb begin
    block_nxt = '0;
    for (int k = 0; k < NIBBLES; k++) begin
      if (ctl.mode == MODE_ENCODE) begin
        for (int j = 0; j < CODE_BITS; j++) begin
          block_nxt[NIBBLES*j + k] = lanes[k][j];
        end
      end else begin
        block_nxt[DATA_BITS*k +: DATA_BITS] = lanes[k][DATA_BITS-1:0];
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (load_ok) begin
      valid_nxt = ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      block_r <= block_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_block = block_r;

endmodule

// ===== hw/rtl/hamming74_interleave_codec.sv =====
// Top level of the Hamming (7,4) interleave codec: sixteen parallel lanes and a merge
// stage with the output register. Depends on hic_pkg, hic_lane and hic_merge.
//
//   channel | direction | handshake              | payload
//   in_     | slave     | in_tvalid / in_tready  | in_tdata = word_low, word_high; in_tuser = mode
//   out_    | master    | out_tvalid / out_tready| out_tdata = result_low, result_high
//
// Every beat passes combinationally through the lanes and appears on the output in the cycle
// after it is accepted; one beat per cycle is sustained while the output is not stalled.
// The single output register is the only register on the path. in_tready is high whenever
// the output register is empty or being emptied in the same cycle, so a stall downstream
// holds the input for exactly as long as the result waits. Reset (synchronous, active low)
// empties the output register; no other state exists.
module hamming74_interleave_codec (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // Fields from bit 0 up: word_low [63:0], word_high [111:64].
  input  logic [hic_pkg::BLOCK_W-1:0]  in_tdata,
  // Fields from bit 0 up: mode [0] (0 encode, 1 decode).
  input  logic                         in_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // Fields from bit 0 up: result_low [63:0], result_high [111:64].
  output logic [hic_pkg::BLOCK_W-1:0]  out_tdata
);
  import hic_pkg::*;

  hic_mode_t  mode;
  hic_lanes_t lane_in;
  hic_lanes_t lane_out;
  hic_ctl_t   ctl;

  assign mode = hic_mode_t'(in_tuser);

  // Lane k sees nibble k of the data on encode. On decode it gathers its code, whose
  // bit j sits at bit 16*j + k of the coded block, which undoes the interleave.
  always_comb begin
    for (int k = 0; k < NIBBLES; k++) begin
      if (mode == MODE_ENCODE) begin
        lane_in[k] = {3'b000, in_tdata[DATA_BITS*k +: DATA_BITS]};
      end else begin
        for (int j = 0; j < CODE_BITS; j++) begin
          lane_in[k][j] = in_tdata[NIBBLES*j + k];
        end
      end
    end
  end

  for (genvar k = 0; k < NIBBLES; k++) begin : g_lane
    hic_lane u_lane (
      .mode     (mode),
      .word_in  (lane_in[k]),
      .word_out (lane_out[k])
    );
  end

  assign ctl.valid = in_tvalid;
  assign ctl.mode  = mode;

  hic_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .lanes     (lane_out),
    .load_ok   (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_block (out_tdata)
  );

endmodule

// ===== hw/rtl/hic_checker.sv =====
// Port-level checker for the Hamming (7,4) interleave codec, bound to the top level.
// Depends on hic_pkg and hamming74_interleave_codec.
module hic_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic [hic_pkg::BLOCK_W-1:0] in_tdata,
  input logic                        in_tuser,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [hic_pkg::BLOCK_W-1:0] out_tdata
);
  import hic_pkg::*;

  // A waiting result keeps its beat.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat changed while stalled");

  // An accepted beat shows up on the output in the next cycle.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted beat did not reach the output");

  // An empty output register never blocks the input.
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // Decoded beats carry zero in the upper result bytes.
  a_decode_high: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> out_tdata[BLOCK_W-1:LOW_W] == '0)
    else $error("decode left nonzero upper bytes");

  // Encoding all-zero data gives an all-zero coded block.
  a_encode_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser && in_tdata[LOW_W-1:0] == '0
    |=> out_tdata == '0)
    else $error("zero data did not encode to zero");

endmodule

bind hamming74_interleave_codec hic_checker u_hic_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
